// File: hw/rtl/gb3_pkg.sv
// shared types, constants and the kernel function of the 3x3 gaussian blur
package gb3_pkg;

   // default image size limits
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int MIN_SIZE       = 3;

   // field widths
   localparam int PIX_W       = 8;
   localparam int OUT_ROW_W   = 10;
   localparam int OUT_COL_W   = 8;
   localparam int CFG_WIDTH_W = 9;
   localparam int CFG_HEIGHT_W = 11;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int SUM_W       = 12;

   // register reset values
   localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = CFG_WIDTH_W'(188);
   localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = CFG_HEIGHT_W'(120);

   // register index, taken from paddr bit 2
   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } gb3_reg_type;

   // one 3x3 neighborhood, row major, top row first
   typedef struct packed {
      logic [PIX_W-1:0] p00, p01, p02;
      logic [PIX_W-1:0] p10, p11, p12;
      logic [PIX_W-1:0] p20, p21, p22;
   } gb3_window_type;

   // kernel 1 2 1 / 2 4 2 / 1 2 1, divided by 16 with truncation
   function automatic logic [PIX_W-1:0] gb3_blur(input gb3_window_type win);
      logic [SUM_W-1:0] corner;
      logic [SUM_W-1:0] edges;
      logic [SUM_W-1:0] sum;
      corner = SUM_W'(win.p00) + SUM_W'(win.p02) + SUM_W'(win.p20) + SUM_W'(win.p22);
      edges  = SUM_W'(win.p01) + SUM_W'(win.p10) + SUM_W'(win.p12) + SUM_W'(win.p21);
      sum    = corner + (edges << 1) + (SUM_W'(win.p11) << 2);
      return sum[SUM_W-1:4];
   endfunction

endpackage

// File: hw/rtl/gb3_csr.sv
// configuration registers and clamped effective image size
module gb3_csr import gb3_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [WW-1:0]         eff_width,
   output logic [HW-1:0]         eff_height
);

   localparam int WCMP = (WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W;
   localparam int HCMP = (HW > CFG_HEIGHT_W) ? HW : CFG_HEIGHT_W;

   logic [CFG_WIDTH_W-1:0]  image_width_ff;
   logic [CFG_HEIGHT_W-1:0] image_height_ff;
   logic                    wr_en;
   gb3_reg_type             reg_sel;
   logic [WCMP-1:0]         width_ext;
   logic [HCMP-1:0]         height_ext;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = gb3_reg_type'(paddr[2]);

   // register write
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= RST_IMAGE_WIDTH;
         image_height_ff <= RST_IMAGE_HEIGHT;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_IMAGE_WIDTH:  image_width_ff  <= pwdata[CFG_WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= pwdata[CFG_HEIGHT_W-1:0];
            default:          ;
         endcase
      end
   end

   // register read
   always_comb begin
      unique case (reg_sel)
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_W'(image_width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_W'(image_height_ff);
         default:          prdata = '0;
      endcase
   end

   // clamp sizes into the supported range
   always_comb begin
      width_ext  = WCMP'(image_width_ff);
      height_ext = HCMP'(image_height_ff);
      if (width_ext < WCMP'(MIN_SIZE))       eff_width = WW'(MIN_SIZE);
      else if (width_ext > WCMP'(MAX_WIDTH)) eff_width = WW'(MAX_WIDTH);
      else                                   eff_width = WW'(width_ext);
      if (height_ext < HCMP'(MIN_SIZE))        eff_height = HW'(MIN_SIZE);
      else if (height_ext > HCMP'(MAX_HEIGHT)) eff_height = HW'(MAX_HEIGHT);
      else                                     eff_height = HW'(height_ext);
   end

endmodule

// File: hw/rtl/gaussian_blur_3x3_stream_top.sv
// streaming 3x3 gaussian blur: position tracking, line stores, window and output register
// a pixel accepted passes stage b and the output register before rsp_valid shows its result
// throughput: one pixel per cycle unless stalled; line stores read and written once per cycle
// border pixels are consumed without a result transaction
// reset clears position counters, window, pipeline and output valid; line stores are not cleared
// configuration registers reset to a width of 188 and a height of 120
module gaussian_blur_3x3_stream_top import gb3_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pixel_value,
   input  logic                  req_frame_start,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_filtered_value,
   output logic [OUT_ROW_W-1:0]  rsp_out_row,
   output logic [OUT_COL_W-1:0]  rsp_out_col,
   output logic                  rsp_frame_done,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int WCW = CW + 1;
   localparam int HCW = RW + 1;

   logic [WW-1:0] eff_width;
   logic [HW-1:0] eff_height;

   gb3_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .eff_width  (eff_width),
      .eff_height (eff_height)
   );

   // position counters and stage registers
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic             b_valid_ff;
   logic [PIX_W-1:0] b_px_ff;
   logic [CW-1:0]    b_col_ff;
   logic [RW-1:0]    b_row_ff;
   logic             b_emit_ff;
   logic             b_done_ff;
   logic [PIX_W-1:0] top_ff;
   logic [PIX_W-1:0] mid_ff;
   logic [PIX_W-1:0] win_ff [6];

   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_value_ff;
   logic [RW-1:0]    rsp_row_ff;
   logic [CW-1:0]    rsp_col_ff;
   logic             rsp_done_ff;

   // handshake and pipeline flow
   logic             accept;
   logic             out_free;
   logic             out_load;
   logic             b_fire;
   logic             b_ready;
   logic             bypass;

   // stage a position
   logic [CW-1:0]    col_base;
   logic [RW-1:0]    row_base;
   logic             col_wrap;
   logic [HCW-1:0]   row_inc;
   logic [CW-1:0]    a_col;
   logic [RW-1:0]    a_row;
   logic [WCW-1:0]   col_next;
   logic [HCW-1:0]   row_next;
   logic             a_emit;
   logic             a_done;
   logic [WCW-1:0]   width_cmp;
   logic [HCW-1:0]   height_cmp;

   gb3_window_type   window;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign b_fire    = b_valid_ff && (!b_emit_ff || out_free);
   assign b_ready   = !b_valid_ff || b_fire;
   assign accept    = req_valid && b_ready;
   assign req_stall = !b_ready;
   assign out_load  = b_fire && b_emit_ff;

   assign width_cmp  = WCW'(eff_width);
   assign height_cmp = HCW'(eff_height);

   // position of the incoming pixel, with frame start and wrap on a shrunk size
   always_comb begin
      col_base = req_frame_start ? '0 : col_ff;
      row_base = req_frame_start ? '0 : row_ff;
      col_wrap = WCW'(col_base) >= width_cmp;
      a_col    = col_wrap ? '0 : col_base;
      row_inc  = col_wrap ? HCW'(row_base) + HCW'(1) : HCW'(row_base);
      a_row    = (row_inc >= height_cmp) ? '0 : row_inc[RW-1:0];
      a_emit   = (a_row >= RW'(2)) && (a_col >= CW'(2));
      a_done   = (HCW'(a_row) + HCW'(1) == height_cmp)
               && (WCW'(a_col) + WCW'(1) == width_cmp);
   end

   // position after this pixel
   always_comb begin
      col_next = WCW'(a_col) + WCW'(1);
      row_next = HCW'(a_row) + HCW'(1);
      if (col_next >= width_cmp) begin
         col_in = '0;
         row_in = (row_next >= height_cmp) ? '0 : row_next[RW-1:0];
      end else begin
         col_in = col_next[CW-1:0];
         row_in = a_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage b valid
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (accept) begin
         b_valid_ff <= 1'b1;
      end else if (b_fire) begin
         b_valid_ff <= 1'b0;
      end
   end

   // stage b payload
   always_ff @(posedge clock) begin
      if (accept) begin
         b_px_ff   <= req_pixel_value;
         b_col_ff  <= a_col;
         b_row_ff  <= a_row;
         b_emit_ff <= a_emit;
         b_done_ff <= a_done;
      end
   end

   // same column written by stage b in the cycle it is read
   assign bypass = b_fire && (b_col_ff == a_col);

   // line stores: read for the incoming pixel, write back for the finishing one
   always_ff @(posedge clock) begin
      if (accept) begin
         top_ff <= bypass ? mid_ff  : upper_mem[a_col];
         mid_ff <= bypass ? b_px_ff : middle_mem[a_col];
      end
      if (b_fire) begin
         upper_mem[b_col_ff]  <= mid_ff;
         middle_mem[b_col_ff] <= b_px_ff;
      end
   end

   // window columns: 0..2 two columns back, 3..5 one column back
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (b_fire) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_ff;
         win_ff[4] <= mid_ff;
         win_ff[5] <= b_px_ff;
      end
   end

   // 3x3 neighborhood around the pixel one row up and one column left
   always_comb begin
      window.p00 = win_ff[0];
      window.p01 = win_ff[3];
      window.p02 = top_ff;
      window.p10 = win_ff[1];
      window.p11 = win_ff[4];
      window.p12 = mid_ff;
      window.p20 = win_ff[2];
      window.p21 = win_ff[5];
      window.p22 = b_px_ff;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_value_ff <= gb3_blur(window);
         rsp_row_ff   <= b_row_ff - RW'(1);
         rsp_col_ff   <= b_col_ff - CW'(1);
         rsp_done_ff  <= b_done_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_out_row        = OUT_ROW_W'(rsp_row_ff);
   assign rsp_out_col        = OUT_COL_W'(rsp_col_ff);
   assign rsp_frame_done     = rsp_done_ff;

   // stage b holds its pixel while waiting for the output register
   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !b_fire |=> b_valid_ff && $stable(b_col_ff) && $stable(b_px_ff))
      else $error("stage b lost or changed a stalled pixel");

   // a result is loaded only into a free or draining output register
   assert property (@(posedge clock) disable iff (reset)
      out_load |-> !rsp_valid_ff || !rsp_stall)
      else $error("result overwrote a pending transaction");

   // reset leaves counters at the frame origin and the pipeline empty
   assert property (@(posedge clock)
      reset |=> col_ff == '0 && row_ff == '0 && !b_valid_ff && !rsp_valid_ff)
      else $error("state not cleared by reset");

endmodule

// File: tb/gaussian_blur_3x3_stream_top_tb.sv
// self-checking testbench for the streaming 3x3 gaussian blur top level
`timescale 1ns / 1ps

module gaussian_blur_3x3_stream_top_tb import gb3_pkg::*; ();

   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 300;
   localparam int TALL_ROWS    = 40;
   localparam int MAX_PRINTED  = 100;

   // one filtered pixel as the block reports it
   typedef struct packed {
      logic [PIX_W-1:0]     value;
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic                 done;
   } blur_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pixel_value = '0;
   logic                  req_frame_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIX_W-1:0]      rsp_filtered_value;
   logic [OUT_ROW_W-1:0]  rsp_out_row;
   logic [OUT_COL_W-1:0]  rsp_out_col;
   logic                  rsp_frame_done;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // idling controls
   bit sender_gaps = 1'b1;
   bit receiver_stalls = 1'b1;
   int hold_len = 0;
   int quiet_cycles = 0;
   int error_count = 0;

   // blur predictor state
   logic [CFG_WIDTH_W-1:0]  model_width;
   logic [CFG_HEIGHT_W-1:0] model_height;
   logic [PIX_W-1:0]        upper_row [DEF_MAX_WIDTH];
   logic [PIX_W-1:0]        middle_row [DEF_MAX_WIDTH];
   logic [PIX_W-1:0]        win [6];
   int unsigned             cur_row;
   int unsigned             cur_col;
   blur_result_type         blur_expected_q [$];

   gaussian_blur_3x3_stream_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel_value    (req_pixel_value),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_frame_done     (rsp_frame_done),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   // advance the blur predictor by one pixel and queue the result it causes
   function automatic void predict_blur(input logic [PIX_W-1:0] pix, input logic fs);
      int unsigned w, h, r, c, top, mid, sum;
      blur_result_type res;
      w = clamp_dim(model_width, DEF_MAX_WIDTH);
      h = clamp_dim(model_height, DEF_MAX_HEIGHT);
      if (fs) begin
         cur_row = 0;
         cur_col = 0;
      end
      // position left beyond a shrunk size wraps
      if (cur_col >= w) begin
         cur_col = 0;
         cur_row++;
      end
      if (cur_row >= h)
         cur_row = 0;
      r = cur_row;
      c = cur_col;
      top = upper_row[c];
      mid = middle_row[c];
      if (r >= 2 && c >= 2) begin
         sum = win[0] + win[2] + top + pix
               + 2 * (win[1] + win[3] + win[5] + mid) + 4 * win[4];
         res.value = PIX_W'(sum / 16);
         res.row   = OUT_ROW_W'(r - 1);
         res.col   = OUT_COL_W'(c - 1);
         res.done  = (r == h - 1) && (c == w - 1);
         blur_expected_q.push_back(res);
      end
      upper_row[c]  = mid;
      middle_row[c] = pix;
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = PIX_W'(top);
      win[4] = PIX_W'(mid);
      win[5] = pix;
      // step to the next position, wrapping at row and frame end
      cur_col = c + 1;
      if (cur_col >= w) begin
         cur_col = 0;
         cur_row = r + 1;
         if (cur_row >= h)
            cur_row = 0;
      end
   endfunction

   // offer one pixel, with random gaps in front, until the block takes it
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
      while (sender_gaps && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= pix;
      req_frame_start <= fs;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_blur(pix, fs);
   endtask

   task automatic send_random_pixels(input int count, input logic fs_first);
      for (int i = 0; i < count; i++)
         send_pixel(PIX_W'($urandom_range(255)), (i == 0) ? fs_first : 1'b0);
   endtask

   // stop sending and let every outstanding transaction come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (blur_expected_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write followed by a read back of the same register
   task automatic write_size_reg(input gb3_reg_type idx, input int unsigned value);
      logic [CSR_DATA_W-1:0] readback;
      logic [CSR_DATA_W-1:0] want;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx == REG_IMAGE_WIDTH) begin
         model_width = CFG_WIDTH_W'(value);
         want = CSR_DATA_W'(model_width);
      end else begin
         model_height = CFG_HEIGHT_W'(value);
         want = CSR_DATA_W'(model_height);
      end
      if (readback !== want)
         report_mismatch("register read back", readback, want);
   endtask

   // smallest frame, full-scale and zero pixels, end-of-frame wrap, clamped sizes
   task automatic test_min_frame();
      write_size_reg(REG_IMAGE_WIDTH, 3);
      write_size_reg(REG_IMAGE_HEIGHT, 3);
      for (int i = 0; i < 9; i++)
         send_pixel(8'hFF, i == 0);
      // next frame starts on its own after the last pixel
      for (int i = 0; i < 9; i++)
         send_pixel(8'h00, 1'b0);
      wait_drained();
      write_size_reg(REG_IMAGE_WIDTH, 1);
      write_size_reg(REG_IMAGE_HEIGHT, 0);
      send_pixel(8'h55, 1'b0);
      send_pixel(8'hAA, 1'b0);
      // frame start in the middle of a row
      for (int i = 0; i < 9; i++)
         send_pixel((i % 2 == 0) ? 8'hAA : 8'h55, i == 0);
      wait_drained();
   endtask

   // widest rows: width register above the limit clamps to the line store size
   task automatic test_wide_frame();
      write_size_reg(REG_IMAGE_WIDTH, 511);
      write_size_reg(REG_IMAGE_HEIGHT, 3);
      send_random_pixels(3 * DEF_MAX_WIDTH, 1'b1);
      wait_drained();
      write_size_reg(REG_IMAGE_WIDTH, DEF_MAX_WIDTH);
   endtask

   // narrow rows under the height register at all ones
   task automatic test_tall_frame();
      write_size_reg(REG_IMAGE_WIDTH, 3);
      write_size_reg(REG_IMAGE_HEIGHT, 2047);
      send_random_pixels(3 * TALL_ROWS, 1'b1);
      wait_drained();
   endtask

   // sizes shrunk while the position lies beyond them
   task automatic test_shrink_mid_frame();
      write_size_reg(REG_IMAGE_WIDTH, 20);
      write_size_reg(REG_IMAGE_HEIGHT, 8);
      send_random_pixels(75, 1'b1);
      wait_drained();
      write_size_reg(REG_IMAGE_WIDTH, 8);
      send_random_pixels(20, 1'b0);
      wait_drained();
      write_size_reg(REG_IMAGE_HEIGHT, 3);
      send_random_pixels(72, 1'b0);
      wait_drained();
   endtask

   // back to back transactions on both sides
   task automatic test_full_rate();
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      write_size_reg(REG_IMAGE_WIDTH, 16);
      write_size_reg(REG_IMAGE_HEIGHT, 10);
      send_random_pixels(160, 1'b1);
      wait_drained();
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // long receiver hold-off, then a sender pause in the middle of a frame
   task automatic test_backpressure();
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      write_size_reg(REG_IMAGE_WIDTH, 12);
      write_size_reg(REG_IMAGE_HEIGHT, 12);
      hold_len <= HOLD_CYCLES;
      send_random_pixels(144, 1'b1);
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      send_random_pixels(60, 1'b0);
      wait_drained();
      send_random_pixels(84, 1'b0);
      wait_drained();
   endtask

   // random sizes and frames with random content, some stray frame starts
   task automatic test_random_frames();
      int sent, n, w_old, we, he, w_new, h_new, kind, pix_mode, level;
      logic fs_first;
      logic fs;
      logic [PIX_W-1:0] pix;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_drained();
         w_old = clamp_dim(model_width, DEF_MAX_WIDTH);
         kind = $urandom_range(99);
         if (kind < 6) w_new = $urandom_range(2);
         else if (kind < 9) w_new = $urandom_range(511, 257);
         else if (kind < 12) w_new = DEF_MAX_WIDTH;
         else w_new = $urandom_range(24, 3);
         kind = $urandom_range(99);
         if (kind < 6) h_new = $urandom_range(2);
         else if (kind < 9) h_new = $urandom_range(2047, 1025);
         else if (kind < 12) h_new = DEF_MAX_HEIGHT;
         else h_new = $urandom_range(12, 3);
         if ($urandom_range(3) != 0)
            write_size_reg(REG_IMAGE_WIDTH, w_new);
         if ($urandom_range(3) != 0)
            write_size_reg(REG_IMAGE_HEIGHT, h_new);
         we = clamp_dim(model_width, DEF_MAX_WIDTH);
         he = clamp_dim(model_height, DEF_MAX_HEIGHT);
         // a wider row needs a fresh frame so no stale line store entry is read
         fs_first = (we > w_old) || ($urandom_range(1) == 1);
         if (we * he > 300)
            n = we * $urandom_range(5, 3) + $urandom_range(we);
         else
            n = we * he * $urandom_range(3, 1) + $urandom_range(2 * we);
         // keep the total near the item budget
         if (n > RANDOM_ITEMS - sent)
            n = RANDOM_ITEMS - sent;
         pix_mode = $urandom_range(2);
         level = $urandom_range(240);
         for (int i = 0; i < n; i++) begin
            case (pix_mode)
               0: pix = PIX_W'($urandom_range(255));
               1: pix = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
               default: pix = PIX_W'(level + $urandom_range(15));
            endcase
            fs = (i == 0) ? fs_first : ($urandom_range(99) < 2);
            send_pixel(pix, fs);
         end
         sent += n;
      end
      wait_drained();
   endtask

   // receiver stall: random, or held for a counted stretch on request
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else if (hold_len > 0) begin
         rsp_stall <= 1'b1;
         hold_len <= hold_len - 1;
      end else
         rsp_stall <= receiver_stalls && ($urandom_range(99) < 18);
   end

   // compare each result transaction with the oldest prediction
   always @(posedge clock) begin : check_results
      blur_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (blur_expected_q.size() == 0)
            report_mismatch("unexpected result at out_row", rsp_out_row, -1);
         else begin
            want = blur_expected_q.pop_front();
            if (rsp_filtered_value !== want.value)
               report_mismatch("filtered_value", rsp_filtered_value, want.value);
            if (rsp_out_row !== want.row)
               report_mismatch("out_row", rsp_out_row, want.row);
            if (rsp_out_col !== want.col)
               report_mismatch("out_col", rsp_out_col, want.col);
            if (rsp_frame_done !== want.done)
               report_mismatch("frame_done", rsp_frame_done, want.done);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("gaussian_blur_3x3_stream_top_tb: done, errors");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      // predictor state after reset
      model_width  = RST_IMAGE_WIDTH;
      model_height = RST_IMAGE_HEIGHT;
      for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
      for (int i = 0; i < 6; i++)
         win[i] = '0;
      cur_row = 0;
      cur_col = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_min_frame();
      test_wide_frame();
      test_tall_frame();
      test_shrink_mid_frame();
      test_full_rate();
      test_backpressure();
      test_random_frames();
      wait_drained();
      if (error_count == 0)
         $display("gaussian_blur_3x3_stream_top_tb: done, clean");
      else
         $display("gaussian_blur_3x3_stream_top_tb: done, errors");
      $finish;
   end

endmodule
